[sv/mbl_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mbl_pkg: shared types and constants of the MSE / BCE loss core
// Field formats, datapath widths, controller codes and the log2 fraction table.
// ----------------------------------------------------------------------------
package mbl_pkg;

    localparam int FRAC_BITS      = 16;
    localparam int LOG_TABLE_BITS = 8;
    localparam int LOG_TAB_SIZE   = 1 << LOG_TABLE_BITS;

    localparam int DATA_W     = 32;
    localparam int ROWS_W     = 16;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 1;
    localparam int BLOSS_W    = 31;

    // divider: signed 64-bit dividend, positive 16-bit divisor, 4 quotient bits a cycle
    localparam int QUOT_W         = 64;
    localparam int DEN_W          = 16;
    localparam int DIV_RADIX_BITS = 4;
    localparam int DIV_STEPS      = QUOT_W / DIV_RADIX_BITS;
    localparam int DIV_CNT_W      = $clog2(DIV_STEPS + 1);

    // log magnitude: (FRAC_BITS - msb) integer part plus fraction
    localparam int LOG2_W = $clog2(FRAC_BITS);
    localparam int EXP_W  = $clog2(FRAC_BITS + 1);
    localparam int MAG_W  = FRAC_BITS + EXP_W;
    localparam int L_W    = MAG_W;

    localparam int MUL_W  = DATA_W + 2;
    localparam int PROD_W = 2 * MUL_W;
    localparam int ACC_W  = 56;
    localparam int TERM_W = 2 * DATA_W - FRAC_BITS + 1;
    localparam int G_W    = 52;
    localparam int SUM_W  = 64;

    localparam logic [31:0] LN2_Q32 = 32'd2977044471;

    localparam logic [CFG_IDX_W-1:0] REG_LOSS_MODE  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BATCH_ROWS = 1'd1;

    typedef struct packed {
        logic signed [DATA_W-1:0] prediction;
        logic signed [DATA_W-1:0] target;
        logic                     batch_end;
    } req_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] gradient;
        logic [BLOSS_W-1:0]       batch_loss;
        logic                     loss_valid;
    } res_t;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_PREP,
        OP_LOGIDX,
        OP_MSE_START,
        OP_MSE_TERM,
        OP_BCE_M1,
        OP_BCE_M2,
        OP_BCE_M3,
        OP_BCE_M4,
        OP_BCE_M5,
        OP_BCE_M6,
        OP_BCE_D2,
        OP_BCE_D3,
        OP_BCE_D4,
        OP_GRAD,
        OP_ACC,
        OP_LOSS_START,
        OP_LOSS,
        OP_EMIT
    } op_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_PREP,
        S_LOGIDX,
        S_MSE_START,
        S_MSE_TERM,
        S_BCE_M1,
        S_BCE_M2,
        S_BCE_M3,
        S_BCE_M4,
        S_BCE_M5,
        S_BCE_M6,
        S_WAIT_D1,
        S_BCE_D2,
        S_WAIT_D2,
        S_BCE_D3,
        S_BCE_D4,
        S_WAIT_G,
        S_GRAD,
        S_ACC,
        S_LOSS_START,
        S_WAIT_L,
        S_LOSS,
        S_EMIT
    } state_t;

    typedef struct packed {
        op_t op;
    } cmd_t;

    typedef struct packed {
        logic div_busy;
        logic mode;
        logic batch_end;
        logic out_free;
    } stat_t;

    typedef logic [FRAC_BITS-1:0] log_tab_t [LOG_TAB_SIZE];

    // log2(1 + i/2^LOG_TABLE_BITS) by repeated squaring in Q2.30
    function automatic log_tab_t log_tab_build();
        log_tab_t             tab;
        logic [63:0]          y;
        logic [FRAC_BITS-1:0] r;
        for (int i = 0; i < LOG_TAB_SIZE; i++)
        begin
            y = (64'(LOG_TAB_SIZE) + 64'(i)) << (30 - LOG_TABLE_BITS);
            r = '0;
            for (int k = 0; k < FRAC_BITS; k++)
            begin
                y = (y * y) >> 30;
                r = r << 1;
                if (y >= (64'd2 << 30))
                begin
                    r[0] = 1'b1;
                    y    = y >> 1;
                end
            end
            tab[i] = r;
        end
        return tab;
    endfunction

    localparam log_tab_t LOG_TAB = log_tab_build();

endpackage
`default_nettype wire

[sv/mbl_div.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mbl_div: iterative signed divider
// Signed 64-bit dividend by positive 16-bit divisor, truncating toward zero,
// four quotient bits per cycle.
// ----------------------------------------------------------------------------
module mbl_div
    import mbl_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     start,
    input  wire logic signed [QUOT_W-1:0] dividend,
    input  wire logic [DEN_W-1:0]         divisor,
    output logic                          busy,
    output logic signed [QUOT_W-1:0]      quotient
);

    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 neg_reg;
    logic [QUOT_W-1:0]    num_reg;
    logic [DEN_W-1:0]     rem_reg;
    logic [DEN_W-1:0]     den_reg;
    logic [QUOT_W-1:0]    num_next;
    logic [DEN_W-1:0]     rem_next;

    // shift-subtract, radix 16
    always_comb
    begin
        logic [DEN_W:0]    r17;
        logic [QUOT_W-1:0] n;
        logic [DEN_W-1:0]  r;
        n = num_reg;
        r = rem_reg;
        for (int k = 0; k < DIV_RADIX_BITS; k++)
        begin
            r17 = {r, n[QUOT_W-1]};
            n   = {n[QUOT_W-2:0], 1'b0};
            if (r17 >= {1'b0, den_reg})
            begin
                r17  = r17 - {1'b0, den_reg};
                n[0] = 1'b1;
            end
            r = r17[DEN_W-1:0];
        end
        num_next = n;
        rem_next = r;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (start)
        begin
            cnt_reg <= DIV_CNT_W'(DIV_STEPS);
        end
        else if (cnt_reg != '0)
        begin
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            neg_reg <= dividend[QUOT_W-1];
            num_reg <= dividend[QUOT_W-1] ? QUOT_W'(-dividend) : QUOT_W'(dividend);
            rem_reg <= '0;
            den_reg <= divisor;
        end
        else if (cnt_reg != '0)
        begin
            num_reg <= num_next;
            rem_reg <= rem_next;
        end
    end

    assign busy     = (cnt_reg != '0);
    assign quotient = neg_reg ? -$signed(num_reg) : $signed(num_reg);

endmodule
`default_nettype wire

[sv/mbl_datapath.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mbl_datapath: operand registers, multiplier, log unit, accumulator
// Executes one operation per cycle as commanded; holds config and result regs.
// ----------------------------------------------------------------------------
module mbl_datapath
    import mbl_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire req_t                  req_data,
    input  wire logic                  res_ready,
    output logic                       res_valid,
    output res_t                       res_data,
    input  wire cmd_t                  cmd,
    output stat_t                      stat
);

    localparam logic [FRAC_BITS-1:0] PC_MAX = {FRAC_BITS{1'b1}};

    logic                     mode_reg;
    logic [ROWS_W-1:0]        rows_reg;
    logic signed [DATA_W-1:0] p_reg;
    logic signed [DATA_W-1:0] t_reg;
    logic                     end_reg;
    logic signed [DATA_W+1:0] d2_reg;
    logic [DATA_W-1:0]        a_reg;
    logic [FRAC_BITS-1:0]     pc_reg;
    logic [FRAC_BITS-1:0]     q_reg;
    logic signed [DATA_W+1:0] u_reg;
    logic [MAG_W-1:0]         mag1_reg;
    logic [MAG_W-1:0]         mag2_reg;
    logic [L_W-1:0]           l1_reg;
    logic [L_W-1:0]           l2_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [TERM_W-1:0] term_reg;
    logic signed [G_W-1:0]    g_reg;
    logic signed [DATA_W-1:0] grad_reg;
    logic [BLOSS_W-1:0]       bloss_reg;
    logic signed [SUM_W-1:0]  sum_reg;
    logic                     res_valid_reg;
    res_t                     res_data_reg;

    logic signed [DATA_W:0]   diff;
    logic [DATA_W:0]          diff_abs;
    logic [ROWS_W-1:0]        rows_eff;
    logic signed [MUL_W-1:0]  mul_a;
    logic signed [MUL_W-1:0]  mul_b;
    logic signed [ACC_W-1:0]  acc_adj;
    logic signed [SUM_W:0]    sum_wide;
    logic signed [SUM_W-1:0]  sum_sat;

    logic                     div_start;
    logic signed [QUOT_W-1:0] div_num;
    logic [DEN_W-1:0]         div_den;
    logic                     div_busy;
    logic signed [QUOT_W-1:0] quot;

    // -ln(x) / ln2 in fixed point, x in [1, 2^FRAC_BITS - 1]
    function automatic logic [MAG_W-1:0] log2_mag(input logic [FRAC_BITS-1:0] x);
        logic [LOG2_W-1:0]         m;
        logic [FRAC_BITS-1:0]      norm;
        logic [LOG_TABLE_BITS-1:0] idx;
        m = '0;
        for (int i = 0; i < FRAC_BITS; i++)
        begin
            if (x[i])
            begin
                m = LOG2_W'(i);
            end
        end
        norm = x << (LOG2_W'(FRAC_BITS - 1) - m);
        idx  = norm[FRAC_BITS-2 -: LOG_TABLE_BITS];
        return {EXP_W'(FRAC_BITS) - EXP_W'(m), {FRAC_BITS{1'b0}}}
               - {{EXP_W{1'b0}}, LOG_TAB[idx]};
    endfunction

    assign diff     = {p_reg[DATA_W-1], p_reg} - {t_reg[DATA_W-1], t_reg};
    assign diff_abs = diff[DATA_W] ? (DATA_W + 1)'(-diff) : (DATA_W + 1)'(diff);
    assign rows_eff = (rows_reg == '0) ? ROWS_W'(1) : rows_reg;

    // multiplier operand select
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (cmd.op)
            OP_MSE_START:
            begin
                mul_a = {2'b00, a_reg};
                mul_b = {2'b00, a_reg};
            end
            OP_BCE_M1:
            begin
                mul_a = {{(MUL_W - MAG_W){1'b0}}, mag1_reg};
                mul_b = {{(MUL_W - 32){1'b0}}, LN2_Q32};
            end
            OP_BCE_M2:
            begin
                mul_a = {{(MUL_W - MAG_W){1'b0}}, mag2_reg};
                mul_b = {{(MUL_W - 32){1'b0}}, LN2_Q32};
            end
            OP_BCE_M3:
            begin
                mul_a = {{2{t_reg[DATA_W-1]}}, t_reg};
                mul_b = {{(MUL_W - L_W){1'b0}}, l1_reg};
            end
            OP_BCE_M4:
            begin
                mul_a = u_reg;
                mul_b = {{(MUL_W - L_W){1'b0}}, l2_reg};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // divider operand select
    always_comb
    begin
        div_start = 1'b0;
        div_num   = sum_reg;
        div_den   = rows_eff;
        unique case (cmd.op)
            OP_MSE_START:
            begin
                div_start = 1'b1;
                div_num   = {{(QUOT_W - DATA_W - 2){d2_reg[DATA_W+1]}}, d2_reg};
            end
            OP_BCE_M1:
            begin
                div_start = 1'b1;
                div_num   = {{(QUOT_W - DATA_W - FRAC_BITS){t_reg[DATA_W-1]}}, t_reg,
                             {FRAC_BITS{1'b0}}};
                div_den   = pc_reg;
            end
            OP_BCE_D2:
            begin
                div_start = 1'b1;
                div_num   = {{(QUOT_W - DATA_W - 2 - FRAC_BITS){u_reg[DATA_W+1]}}, u_reg,
                             {FRAC_BITS{1'b0}}};
                div_den   = q_reg;
            end
            OP_BCE_D4:
            begin
                div_start = 1'b1;
                div_num   = {{(QUOT_W - G_W){g_reg[G_W-1]}}, g_reg};
            end
            OP_LOSS_START:
            begin
                div_start = 1'b1;
            end
            default:
            begin
                div_start = 1'b0;
            end
        endcase
    end

    // truncate toward zero before dropping fraction bits
    assign acc_adj = acc_reg + (acc_reg[ACC_W-1] ? ACC_W'((1 << FRAC_BITS) - 1) : ACC_W'(0));

    assign sum_wide = {sum_reg[SUM_W-1], sum_reg}
                    + {{(SUM_W + 1 - TERM_W){term_reg[TERM_W-1]}}, term_reg};
    assign sum_sat  = (sum_wide[SUM_W] != sum_wide[SUM_W-1])
                    ? {sum_wide[SUM_W], {(SUM_W - 1){~sum_wide[SUM_W]}}}
                    : sum_wide[SUM_W-1:0];

    mbl_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_num),
        .divisor  (div_den),
        .busy     (div_busy),
        .quotient (quot)
    );

    // config, accumulator, output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= 1'b0;
            rows_reg      <= ROWS_W'(1);
            sum_reg       <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_LOSS_MODE:  mode_reg <= cfg_data[0];
                    REG_BATCH_ROWS: rows_reg <= cfg_data[ROWS_W-1:0];
                endcase
            end
            if (cmd.op == OP_ACC)
            begin
                sum_reg <= sum_sat;
            end
            else if (cmd.op == OP_LOSS_START)
            begin
                sum_reg <= '0;
            end
            if (cmd.op == OP_EMIT)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (res_ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (cmd.op)
            OP_LOAD:
            begin
                p_reg     <= req_data.prediction;
                t_reg     <= req_data.target;
                end_reg   <= req_data.batch_end;
                bloss_reg <= '0;
            end
            OP_PREP:
            begin
                d2_reg <= {diff, 1'b0};
                a_reg  <= diff_abs[DATA_W-1:0];
                if (p_reg[DATA_W-1] || (p_reg == '0))
                begin
                    pc_reg <= FRAC_BITS'(1);
                end
                else if (|p_reg[DATA_W-2:FRAC_BITS])
                begin
                    pc_reg <= PC_MAX;
                end
                else
                begin
                    pc_reg <= p_reg[FRAC_BITS-1:0];
                end
                u_reg <= (DATA_W + 2)'(1 << FRAC_BITS) - {{2{t_reg[DATA_W-1]}}, t_reg};
            end
            OP_LOGIDX:
            begin
                q_reg    <= FRAC_BITS'((FRAC_BITS + 1)'(1 << FRAC_BITS) - {1'b0, pc_reg});
                mag1_reg <= log2_mag(pc_reg);
                mag2_reg <= log2_mag(FRAC_BITS'((FRAC_BITS + 1)'(1 << FRAC_BITS)
                                                - {1'b0, pc_reg}));
            end
            OP_MSE_START:
            begin
                prod_reg <= mul_a * mul_b;
            end
            OP_MSE_TERM:
            begin
                term_reg <= {1'b0, prod_reg[2*DATA_W-1:FRAC_BITS]};
            end
            OP_BCE_M1:
            begin
                prod_reg <= mul_a * mul_b;
            end
            OP_BCE_M2:
            begin
                l1_reg   <= prod_reg[32 +: L_W];
                prod_reg <= mul_a * mul_b;
            end
            OP_BCE_M3:
            begin
                l2_reg   <= prod_reg[32 +: L_W];
                prod_reg <= mul_a * mul_b;
            end
            OP_BCE_M4:
            begin
                acc_reg  <= prod_reg[ACC_W-1:0];
                prod_reg <= mul_a * mul_b;
            end
            OP_BCE_M5:
            begin
                acc_reg <= acc_reg + prod_reg[ACC_W-1:0];
            end
            OP_BCE_M6:
            begin
                term_reg <= TERM_W'(acc_adj >>> FRAC_BITS);
            end
            OP_BCE_D2:
            begin
                g_reg <= G_W'(-quot);
            end
            OP_BCE_D3:
            begin
                g_reg <= g_reg + G_W'(quot);
            end
            OP_GRAD:
            begin
                if (quot > QUOT_W'(64'sh7FFF_FFFF))
                begin
                    grad_reg <= 32'sh7FFF_FFFF;
                end
                else if (quot < -QUOT_W'(64'sh8000_0000))
                begin
                    grad_reg <= 32'sh8000_0000;
                end
                else
                begin
                    grad_reg <= quot[DATA_W-1:0];
                end
            end
            OP_LOSS:
            begin
                if (quot[QUOT_W-1])
                begin
                    bloss_reg <= '0;
                end
                else if (|quot[QUOT_W-2:BLOSS_W])
                begin
                    bloss_reg <= {BLOSS_W{1'b1}};
                end
                else
                begin
                    bloss_reg <= quot[BLOSS_W-1:0];
                end
            end
            OP_EMIT:
            begin
                res_data_reg.gradient   <= grad_reg;
                res_data_reg.batch_loss <= bloss_reg;
                res_data_reg.loss_valid <= end_reg;
            end
            default:
            begin
            end
        endcase
    end

    assign res_valid      = res_valid_reg;
    assign res_data       = res_data_reg;
    assign stat.div_busy  = div_busy;
    assign stat.mode      = mode_reg;
    assign stat.batch_end = end_reg;
    assign stat.out_free  = !res_valid_reg || res_ready;

endmodule
`default_nettype wire

[sv/mbl_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mbl_ctrl: sequencer of the loss core
// Steps the datapath through one request: prep, log/multiply, divides, emit.
// ----------------------------------------------------------------------------
module mbl_ctrl
    import mbl_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  req_valid,
    output logic       req_ready,
    input  wire stat_t stat,
    output cmd_t       cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd.op     = OP_NONE;
        req_ready  = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.op     = OP_LOAD;
                    state_next = S_PREP;
                end
            end
            S_PREP:
            begin
                cmd.op     = OP_PREP;
                state_next = stat.mode ? S_LOGIDX : S_MSE_START;
            end
            S_MSE_START:
            begin
                cmd.op     = OP_MSE_START;
                state_next = S_MSE_TERM;
            end
            S_MSE_TERM:
            begin
                cmd.op     = OP_MSE_TERM;
                state_next = S_WAIT_G;
            end
            S_LOGIDX:
            begin
                cmd.op     = OP_LOGIDX;
                state_next = S_BCE_M1;
            end
            S_BCE_M1:
            begin
                cmd.op     = OP_BCE_M1;
                state_next = S_BCE_M2;
            end
            S_BCE_M2:
            begin
                cmd.op     = OP_BCE_M2;
                state_next = S_BCE_M3;
            end
            S_BCE_M3:
            begin
                cmd.op     = OP_BCE_M3;
                state_next = S_BCE_M4;
            end
            S_BCE_M4:
            begin
                cmd.op     = OP_BCE_M4;
                state_next = S_BCE_M5;
            end
            S_BCE_M5:
            begin
                cmd.op     = OP_BCE_M5;
                state_next = S_BCE_M6;
            end
            S_BCE_M6:
            begin
                cmd.op     = OP_BCE_M6;
                state_next = S_WAIT_D1;
            end
            S_WAIT_D1:
            begin
                if (!stat.div_busy)
                begin
                    state_next = S_BCE_D2;
                end
            end
            S_BCE_D2:
            begin
                cmd.op     = OP_BCE_D2;
                state_next = S_WAIT_D2;
            end
            S_WAIT_D2:
            begin
                if (!stat.div_busy)
                begin
                    state_next = S_BCE_D3;
                end
            end
            S_BCE_D3:
            begin
                cmd.op     = OP_BCE_D3;
                state_next = S_BCE_D4;
            end
            S_BCE_D4:
            begin
                cmd.op     = OP_BCE_D4;
                state_next = S_WAIT_G;
            end
            S_WAIT_G:
            begin
                if (!stat.div_busy)
                begin
                    state_next = S_GRAD;
                end
            end
            S_GRAD:
            begin
                cmd.op     = OP_GRAD;
                state_next = S_ACC;
            end
            S_ACC:
            begin
                cmd.op     = OP_ACC;
                state_next = stat.batch_end ? S_LOSS_START : S_EMIT;
            end
            S_LOSS_START:
            begin
                cmd.op     = OP_LOSS_START;
                state_next = S_WAIT_L;
            end
            S_WAIT_L:
            begin
                if (!stat.div_busy)
                begin
                    state_next = S_LOSS;
                end
            end
            S_LOSS:
            begin
                cmd.op     = OP_LOSS;
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (stat.out_free)
                begin
                    cmd.op     = OP_EMIT;
                    state_next = S_IDLE;
                end
            end
        endcase
    end

endmodule
`default_nettype wire

[sv/mse_bce_loss_gradient_core.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mse_bce_loss_gradient_core: streaming MSE / binary cross-entropy loss unit
// Per-element gradient and per-batch mean loss, signed Q16.16, saturated.
// ----------------------------------------------------------------------------
// One request at a time: a request carries prediction, target and a batch_end
// flag and yields exactly one response with the element gradient (divided by
// batch_rows) and, on batch_end, the batch loss sum/batch_rows with
// loss_valid set (batch_loss reads 0 otherwise); the running sum then clears.
// loss_mode 0 selects MSE, 1 selects BCE with the prediction clamped to
// [1 LSB, 1 - 1 LSB]; natural logs come from a msb search, a 256-entry log2
// fraction table and a multiply by ln2. Throughput is set by one shared
// iterative divider (4 quotient bits a cycle): MSE needs one division per
// request, BCE three (logs and products overlapped with the first), and a
// batch_end request adds one more for the loss division. A finished
// response waits in an output register, so the next request is accepted
// as soon as the sequencer returns to idle. batch_rows of 0 acts as 1.
// Write loss_mode (index 0) and batch_rows (index 1) only while no request
// is in flight.
// ----------------------------------------------------------------------------
module mse_bce_loss_gradient_core
    import mbl_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  req_valid,
    output logic                       req_ready,
    input  wire req_t                  req_data,
    output logic                       res_valid,
    input  wire logic                  res_ready,
    output res_t                       res_data,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    cmd_t  cmd;
    stat_t stat;

    // sequencer: one operation per cycle to the datapath, none while it waits
    mbl_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // datapath: config regs, multiplier, divider, accumulator, response reg
    mbl_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req_data  (req_data),
        .res_ready (res_ready),
        .res_valid (res_valid),
        .res_data  (res_data),
        .cmd       (cmd),
        .stat      (stat)
    );

endmodule
`default_nettype wire

[sv/mbl_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mbl_checker: port-level checks of the loss core
// Response hold, batch loss gating and one-request-at-a-time acceptance.
// ----------------------------------------------------------------------------
module mbl_checker
    import mbl_pkg::*;
(
    input wire logic clk,
    input wire logic rst_n,
    input wire logic req_valid,
    input wire logic req_ready,
    input wire logic res_valid,
    input wire logic res_ready,
    input wire res_t res_data
);

    // stalled response holds
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_data))
        else $error("response changed while stalled");

    // batch loss only on batch end
    a_loss_gate: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_data.loss_valid |-> res_data.batch_loss == '0)
        else $error("batch_loss nonzero without loss_valid");

    // no second request while one is in flight
    a_one_req: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request accepted back to back");

    // a response cannot appear the cycle after acceptance
    a_no_instant: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !$rose(res_valid))
        else $error("response too early");

endmodule

bind mse_bce_loss_gradient_core mbl_checker u_chk (.*);
`default_nettype wire

[bench/mse_bce_loss_gradient_core_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mse_bce_loss_gradient_core_tb: self-checking bench of the MSE / BCE loss core
// Drives prediction/target requests under both loss modes and several row
// counts, predicts gradient and batch loss in a local fixed-point model and
// checks every response in order, with random idling on both handshakes.
// ----------------------------------------------------------------------------
module mse_bce_loss_gradient_core_tb;
    import mbl_pkg::*;

    localparam longint ONE_Q = 64'sd1 <<< FRAC_BITS;
    localparam longint I64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam longint I64_MIN = -64'sh7FFF_FFFF_FFFF_FFFF - 1;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  req_valid = 1'b0;
    logic                  req_ready;
    req_t                  req_data = '0;
    logic                  res_valid;
    logic                  res_ready = 1'b0;
    res_t                  res_data;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = REG_LOSS_MODE;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    mse_bce_loss_gradient_core dut (.*);

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // model state
    logic         mode_q = 1'b0;
    logic [15:0]  rows_q = 16'd1;
    longint       sum_q = 0;
    res_t         expected_q[$];
    int           errors = 0;
    int           sent = 0;
    int           received = 0;
    int           batches = 0;
    int           send_idle_pct = 0;
    int           recv_stall_pct = 0;
    int           hold_cycles = 0;
    logic [15:0]  frac_lut [LOG_TAB_SIZE];

    // log2(1 + i/256) in Q16 by repeated squaring in Q2.30
    initial
    begin
        logic [63:0] y;
        logic [15:0] r;
        for (int i = 0; i < LOG_TAB_SIZE; i++)
        begin
            y = (64'(LOG_TAB_SIZE) + 64'(i)) << (30 - LOG_TABLE_BITS);
            r = '0;
            for (int k = 0; k < FRAC_BITS; k++)
            begin
                y = (y * y) >> 30;
                r = r << 1;
                if (y >= (64'd2 << 30))
                begin
                    r[0] = 1'b1;
                    y = y >> 1;
                end
            end
            frac_lut[i] = r;
        end
    end

    function automatic longint clip(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    // natural log of x in [1, 2^16-1], Q16, truncated toward zero
    function automatic longint nat_log(longint x);
        int          m;
        longint      lg;
        logic [63:0] idx;
        logic [63:0] mag;
        logic [95:0] prod;
        m = FRAC_BITS - 1;
        while (m > 0 && x[m] == 1'b0)
            m--;
        idx = 64'(x - (64'sd1 <<< m));
        if (m >= LOG_TABLE_BITS)
            idx = idx >> (m - LOG_TABLE_BITS);
        else
            idx = idx << (LOG_TABLE_BITS - m);
        lg = longint'(m - FRAC_BITS) * ONE_Q + longint'(frac_lut[idx[7:0]]);
        mag = 64'(-lg);
        prod = 96'(mag) * 96'(LN2_Q32);
        return -longint'(prod[95:32]);
    endfunction

    function automatic res_t predict_loss_grad(req_t r);
        res_t        o;
        longint      p, t, d, g, term, rows, pc, q, u, bl;
        logic [63:0] a;
        logic [127:0] sq;
        p = longint'(r.prediction);
        t = longint'(r.target);
        rows = rows_q == 0 ? 1 : longint'(rows_q);
        if (mode_q == 1'b0)
        begin
            d = p - t;
            a = 64'(d < 0 ? -d : d);
            g = (2 * d) / rows;
            sq = 128'(a) * 128'(a);
            term = longint'(sq >> FRAC_BITS);
        end
        else
        begin
            pc = clip(p, 1, ONE_Q - 1);
            q = ONE_Q - pc;
            u = ONE_Q - t;
            g = (-((t * ONE_Q) / pc) + (u * ONE_Q) / q) / rows;
            term = -((t * nat_log(pc) + u * nat_log(q)) / ONE_Q);
        end
        g = clip(g, -64'sd2147483648, 64'sd2147483647);
        if (term > 0 && sum_q > I64_MAX - term)
            sum_q = I64_MAX;
        else if (term < 0 && sum_q < I64_MIN - term)
            sum_q = I64_MIN;
        else
            sum_q = sum_q + term;
        bl = 0;
        if (r.batch_end)
        begin
            bl = clip(sum_q / rows, 0, 64'sh7FFF_FFFF);
            sum_q = 0;
        end
        o.gradient = g[31:0];
        o.batch_loss = bl[30:0];
        o.loss_valid = r.batch_end;
        return o;
    endfunction

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_LOSS_MODE)
            mode_q = val[0];
        else
            rows_q = val;
        @(negedge clk);
    endtask

    // one request; valid drops after each acceptance
    task automatic send_request(logic signed [31:0] p, logic signed [31:0] t, logic last);
        req_t r;
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            @(negedge clk);
        end
        r.prediction = p;
        r.target = t;
        r.batch_end = last;
        req_valid <= 1'b1;
        req_data <= r;
        do
            @(posedge clk);
        while (!req_ready);
        expected_q.push_back(predict_loss_grad(r));
        sent++;
        @(negedge clk);
        req_valid <= 1'b0;
        @(negedge clk);
    endtask

    // response checker
    always @(posedge clk)
    begin
        res_t e;
        if (rst_n && res_valid && res_ready)
        begin
            received++;
            if (expected_q.size() == 0)
            begin
                $error("response with no request outstanding");
                errors++;
            end
            else
            begin
                e = expected_q.pop_front();
                if (res_data.gradient !== e.gradient)
                begin
                    $error("gradient: expected %0d, got %0d", e.gradient, res_data.gradient);
                    errors++;
                end
                if (res_data.batch_loss !== e.batch_loss)
                begin
                    $error("batch_loss: expected %0d, got %0d", e.batch_loss,
                           res_data.batch_loss);
                    errors++;
                end
                if (res_data.loss_valid !== e.loss_valid)
                begin
                    $error("loss_valid: expected %0b, got %0b", e.loss_valid,
                           res_data.loss_valid);
                    errors++;
                end
                if (e.loss_valid)
                    batches++;
            end
        end
    end

    // receiver: random stalls, or a long hold-off when asked
    always @(negedge clk)
    begin
        if (hold_cycles > 0)
        begin
            res_ready <= 1'b0;
            hold_cycles <= hold_cycles - 1;
        end
        else
            res_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    task automatic drain();
        while (expected_q.size() != 0)
            @(negedge clk);
        repeat (100) @(negedge clk);
    endtask

    function automatic logic signed [31:0] rand_prob();
        case ($urandom_range(3))
            0: return $urandom;
            1: return $urandom_range(32'h10000);
            2: return 32'($urandom_range(20)) - 32'sd4;
            default: return 32'h10000 - $urandom_range(8);
        endcase
    endfunction

    function automatic logic signed [31:0] rand_q16();
        case ($urandom_range(2))
            0: return $urandom;
            1: return 32'($signed(16'($urandom)));
            default: return $signed($urandom) >>> $urandom_range(31);
        endcase
    endfunction

    task automatic test_mse_extremes();
        write_reg(REG_LOSS_MODE, 16'd0);
        write_reg(REG_BATCH_ROWS, 16'd1);
        send_request(32'sh7FFF_FFFF, 32'sh8000_0000, 1'b0);
        send_request(32'sh8000_0000, 32'sh7FFF_FFFF, 1'b0);
        send_request(32'sh0001_0000, 32'sh0001_0000, 1'b1);
        send_request(32'sh0003_0000, 32'sh0001_0000, 1'b1);
        send_request(32'hFFFF_FFFF, 32'h0, 1'b1);
        drain();
        write_reg(REG_BATCH_ROWS, 16'hFFFF);
        send_request(32'sh7FFF_FFFF, 32'sh8000_0000, 1'b0);
        send_request(32'sh1234_5678, 32'shF000_0000, 1'b1);
        drain();
    endtask

    task automatic test_bce_cases();
        write_reg(REG_LOSS_MODE, 16'd1);
        write_reg(REG_BATCH_ROWS, 16'd0); // zero rows acts as one
        send_request(32'sh0000_8000, 32'sh0001_0000, 1'b0);
        send_request(32'sh0000_0000, 32'sh0001_0000, 1'b0); // clamp low
        send_request(32'sh8000_0000, 32'sh0000_0000, 1'b0);
        send_request(32'sh0001_0000, 32'sh0000_0000, 1'b0); // clamp high
        send_request(32'sh7FFF_FFFF, 32'sh0001_0000, 1'b1);
        send_request(32'sh0000_4000, 32'sh0005_0000, 1'b0); // target outside [0,1]
        send_request(32'sh0000_C000, 32'shFFFD_0000, 1'b1); // negative target
        send_request(32'sh0000_0001, 32'sh7FFF_FFFF, 1'b0);
        send_request(32'sh0000_0001, 32'sh8000_0000, 1'b1);
        drain();
        // mode change inside a batch keeps the sum
        write_reg(REG_BATCH_ROWS, 16'd3);
        send_request(32'sh0000_6000, 32'sh0000_A000, 1'b0);
        drain();
        write_reg(REG_LOSS_MODE, 16'd0);
        send_request(32'sh0002_0000, 32'sh0000_0000, 1'b1);
        drain();
    endtask

    task automatic run_random(int n, int idle_pct, int stall_pct);
        int left;
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        for (int i = 0; i < n; i++)
        begin
            if (i % 60 == 0)
            begin
                drain();
                write_reg(REG_LOSS_MODE, 16'($urandom_range(1)));
                case ($urandom_range(3))
                    0: write_reg(REG_BATCH_ROWS, 16'd1);
                    1: write_reg(REG_BATCH_ROWS, 16'hFFFF);
                    2: write_reg(REG_BATCH_ROWS, 16'($urandom_range(8)));
                    default: write_reg(REG_BATCH_ROWS, 16'($urandom));
                endcase
                left = $urandom_range(1, 8);
            end
            left--;
            if (mode_q)
                send_request(rand_prob(),
                             $urandom_range(3) == 0 ? rand_q16()
                                                    : 32'($urandom_range(32'h10000)),
                             left <= 0);
            else
                send_request(rand_q16(), rand_q16(), left <= 0);
            if (left <= 0)
                left = $urandom_range(1, 8);
        end
        drain();
    endtask

    // receiver held off while requests keep coming, then a full pause
    task automatic test_backpressure();
        send_idle_pct = 0;
        hold_cycles = 400;
        for (int i = 0; i < 6; i++)
            send_request(rand_q16(), rand_q16(), i == 5);
        drain();
        repeat (50) @(negedge clk);
    endtask

    initial
    begin
        repeat (8) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        test_mse_extremes();
        test_bce_cases();
        test_backpressure();
        run_random(420, 0, 0);
        run_random(420, 64, 0);
        run_random(420, 0, 64);
        run_random(400, 31, 31);
        $display("Covered %0d requests, %0d responses, %0d batch losses in both modes.",
                 sent, received, batches);
        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
